// File: rtl/smpq_pkg.sv
package smpq_pkg;

  // queue depth and derived widths
  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;

  // operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // head fields shown while the queue is empty
  localparam logic signed [DATA_W-1:0] EMPTY_MARK = 32'sh7FFF_FFFF;

  typedef logic [CNT_W-1:0] smpq_cnt_t;

  // per-cycle command broadcast to every cell of the row
  typedef struct packed {
    logic ins;  // insert taken this cycle (queue not full)
    logic rem;  // remove taken this cycle (queue not empty)
  } smpq_ctrl_t;

endpackage

// File: rtl/smpq_cell.sv
module smpq_cell (
  input  logic                                  clk,
  input  smpq_pkg::smpq_ctrl_t                  ctrl,
  input  logic                                  occ,
  input  logic signed [smpq_pkg::DATA_W-1:0]    new_prio,
  input  logic signed [smpq_pkg::DATA_W-1:0]    new_value,
  input  logic                                  left_keep,
  input  logic signed [smpq_pkg::DATA_W-1:0]    left_prio,
  input  logic signed [smpq_pkg::DATA_W-1:0]    left_value,
  input  logic signed [smpq_pkg::DATA_W-1:0]    right_prio,
  input  logic signed [smpq_pkg::DATA_W-1:0]    right_value,
  output logic                                  keep,
  output logic signed [smpq_pkg::DATA_W-1:0]    prio,
  output logic signed [smpq_pkg::DATA_W-1:0]    value
);

  logic signed [smpq_pkg::DATA_W-1:0] prio_r;
  logic signed [smpq_pkg::DATA_W-1:0] value_r;
  logic signed [smpq_pkg::DATA_W-1:0] prio_nxt;
  logic signed [smpq_pkg::DATA_W-1:0] value_nxt;

  // stay in place when occupied and not above the incoming priority
  assign keep = occ && (prio_r <= new_prio);

  // shift up on remove; on insert load the new entry or shift down
  always_comb begin
    prio_nxt  = prio_r;
    value_nxt = value_r;
    if (ctrl.rem) begin
      prio_nxt  = right_prio;
      value_nxt = right_value;
    end else if (ctrl.ins && !keep) begin
      if (left_keep) begin
        prio_nxt  = new_prio;
        value_nxt = new_value;
      end else begin
        prio_nxt  = left_prio;
        value_nxt = left_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    prio_r  <= prio_nxt;
    value_r <= value_nxt;
  end

  assign prio  = prio_r;
  assign value = value_r;

endmodule

// File: rtl/stable_min_priority_queue.sv
// Sorted priority queue of smpq_pkg::CAPACITY entries held in a row of cells, smallest
// priority number at the head; equal priorities leave in arrival order. Every accepted
// item (insert or remove) updates all cells at the same edge, and its result (head
// entry, empty/full flags, drop flag) appears on the out_ channel in the next cycle and
// holds until taken. One item per cycle is sustained as long as out_stall stays low;
// in_stall is high while a result waits and out_stall is high. A remove on an empty
// queue changes nothing, an insert on a full queue is dropped and flagged, and an empty
// head reads 2147483647 in both head fields.
module stable_min_priority_queue (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_operation,
  input  logic signed [smpq_pkg::DATA_W-1:0] in_entry_priority,
  input  logic signed [smpq_pkg::DATA_W-1:0] in_entry_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [smpq_pkg::DATA_W-1:0] out_head_value,
  output logic signed [smpq_pkg::DATA_W-1:0] out_head_priority,
  output logic                               out_is_empty,
  output logic                               out_is_full,
  output logic                               out_insert_dropped
);

  localparam int CAP = smpq_pkg::CAPACITY;

  smpq_pkg::smpq_cnt_t  count_r;
  smpq_pkg::smpq_cnt_t  count_nxt;
  logic                 out_valid_r;
  logic                 dropped_r;
  logic                 accept;
  logic                 empty;
  logic                 full;
  smpq_pkg::smpq_ctrl_t ctrl;

  logic                               keep_w  [CAP];
  logic signed [smpq_pkg::DATA_W-1:0] prio_w  [CAP];
  logic signed [smpq_pkg::DATA_W-1:0] value_w [CAP];

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign empty    = (count_r == '0);
  assign full     = (count_r == smpq_pkg::CNT_W'(CAP));

  // decode the accepted item into the cell command
  always_comb begin
    ctrl.ins = accept && (in_operation == smpq_pkg::OP_INSERT) && !full;
    ctrl.rem = accept && (in_operation == smpq_pkg::OP_REMOVE) && !empty;
  end

  // track the fill level
  always_comb begin
    count_nxt = count_r;
    if (ctrl.ins) begin
      count_nxt = count_r + smpq_pkg::CNT_W'(1);
    end else if (ctrl.rem) begin
      count_nxt = count_r - smpq_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
      dropped_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
        dropped_r   <= (in_operation == smpq_pkg::OP_INSERT) && full;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // build the row of cells
  for (genvar i = 0; i < CAP; i++) begin : g_cell
    logic                               lk;
    logic signed [smpq_pkg::DATA_W-1:0] lp;
    logic signed [smpq_pkg::DATA_W-1:0] lv;
    logic signed [smpq_pkg::DATA_W-1:0] rp;
    logic signed [smpq_pkg::DATA_W-1:0] rv;

    if (i == 0) begin : g_first
      assign lk = 1'b1;
      assign lp = in_entry_priority;
      assign lv = in_entry_value;
    end else begin : g_mid
      assign lk = keep_w[i-1];
      assign lp = prio_w[i-1];
      assign lv = value_w[i-1];
    end

    if (i == CAP - 1) begin : g_last
      assign rp = prio_w[i];
      assign rv = value_w[i];
    end else begin : g_inner
      assign rp = prio_w[i+1];
      assign rv = value_w[i+1];
    end

    smpq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occ         (smpq_pkg::CNT_W'(i) < count_r),
      .new_prio    (in_entry_priority),
      .new_value   (in_entry_value),
      .left_keep   (lk),
      .left_prio   (lp),
      .left_value  (lv),
      .right_prio  (rp),
      .right_value (rv),
      .keep        (keep_w[i]),
      .prio        (prio_w[i]),
      .value       (value_w[i])
    );
  end

  // present the head straight from the first cell; state holds while a result waits
  assign out_valid          = out_valid_r;
  assign out_is_empty       = empty;
  assign out_is_full        = full;
  assign out_insert_dropped = dropped_r;
  assign out_head_value     = empty ? smpq_pkg::EMPTY_MARK : value_w[0];
  assign out_head_priority  = empty ? smpq_pkg::EMPTY_MARK : prio_w[0];

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= smpq_pkg::CNT_W'(CAP))
    else $error("entry count above capacity");

  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted item gave no result");

  a_drop_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_operation == smpq_pkg::OP_INSERT) && full) |=> out_insert_dropped)
    else $error("insert on full queue not flagged");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> $stable(count_r) && $stable(out_head_priority))
    else $error("queue changed while result pending");

  a_head_order: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r > smpq_pkg::CNT_W'(1)) |-> (prio_w[0] <= prio_w[1]))
    else $error("head not the smallest priority");
`endif

endmodule
